// File: sv/aklt_pkg.sv
// Shared constants and register codes for the angle Kalman / low-pass tracker.
`default_nettype none

package aklt_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned VAR_FRAC_BITS_DEF = 16;

  // Variance words are unsigned fixed point, 32 bits wide.
  localparam int unsigned VAR_W = 32;

  // Low-pass coefficient: Q0.16 held in 17 bits so that one is representable.
  localparam int unsigned  ALPHA_W    = 17;
  localparam int unsigned  ALPHA_FRAC = 16;
  localparam logic [16:0]  ALPHA_ONE  = 17'h10000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KALMAN_EN  = 3'd0,
    CFG_LOWPASS_EN = 3'd1,
    CFG_MEAS_NOISE = 3'd2,
    CFG_PROC_NOISE = 3'd3,
    CFG_INIT_VAR   = 3'd4,
    CFG_INIT_ANGLE = 3'd5,
    CFG_LP_ALPHA   = 3'd6
  } cfg_idx_e;

  // Register values after reset.
  localparam logic        RST_KALMAN_EN  = 1'b1;
  localparam logic        RST_LOWPASS_EN = 1'b0;
  localparam logic [31:0] RST_MEAS_NOISE = 32'd65;
  localparam logic [31:0] RST_PROC_NOISE = 32'd7;
  localparam logic [31:0] RST_INIT_VAR   = 32'd65536;
  localparam logic [16:0] RST_LP_ALPHA   = 17'd6554;

endpackage

`default_nettype wire

// File: sv/aklt_stream_if.sv
// Valid/ready channel interfaces for encoder samples and filtered angles.
`default_nettype none

interface aklt_sample_if #(
  parameter int unsigned ANGLE_BITS = aklt_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  read_ok;
  logic [ANGLE_BITS-1:0] angle_sample;

  modport source (output valid, read_ok, angle_sample, input ready);
  modport sink   (input valid, read_ok, angle_sample, output ready);
endinterface

interface aklt_result_if #(
  parameter int unsigned ANGLE_BITS = aklt_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_out;
  logic                  angle_valid;

  modport source (output valid, angle_out, angle_valid, input ready);
  modport sink   (input valid, angle_out, angle_valid, output ready);
endinterface

`default_nettype wire

// File: sv/aklt_div.sv
// Bit-serial restoring divider that forms the Kalman gain, one quotient bit per cycle.
`default_nettype none

module aklt_div #(
  parameter int unsigned QUOT_W = aklt_pkg::VAR_FRAC_BITS_DEF + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aklt_pkg::VAR_W-1:0]  num_i,
  input  logic [aklt_pkg::VAR_W:0]    den_i,
  output logic                        busy_o,
  output logic [QUOT_W-1:0]           quot_o
);
  import aklt_pkg::*;

  localparam int unsigned REM_W = VAR_W + 2;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [VAR_W:0]    den_q;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              ge;
  logic [REM_W-1:0]  rem_sub;

  // The numerator is never above the divisor, so the first bit is the integer bit.
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign rem_d   = {rem_sub[REM_W-2:0], 1'b0};
  assign quot_d  = {quot_q[QUOT_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUOT_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: sv/aklt_mul.sv
// Bit-serial shift-and-add multiplier, most significant multiplier bit first.
`default_nettype none

module aklt_mul #(
  parameter int unsigned MCAND_W = aklt_pkg::ANGLE_BITS_DEF,
  parameter int unsigned MPLR_W  = aklt_pkg::ALPHA_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [MCAND_W-1:0]          mcand_i,
  input  logic [MPLR_W-1:0]           mplr_i,
  output logic                        busy_o,
  output logic [MCAND_W+MPLR_W-1:0]   prod_o
);

  localparam int unsigned PROD_W = MCAND_W + MPLR_W;
  localparam int unsigned CNT_W  = $clog2(MPLR_W + 1);

  logic [MCAND_W-1:0] mcand_q;
  logic [MPLR_W-1:0]  mplr_q;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;

  assign acc_d = {acc_q[PROD_W-2:0], 1'b0}
               + {{MPLR_W{1'b0}}, mcand_q & {MCAND_W{mplr_q[MPLR_W-1]}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(MPLR_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      mplr_q  <= mplr_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      mplr_q <= {mplr_q[MPLR_W-2:0], 1'b0};
      acc_q  <= acc_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// File: sv/angle_kalman_lowpass_tracker.sv
// Top level of the encoder angle tracker: scalar Kalman stage and wrap-aware low-pass.
//
//  Channel    Direction  Payload                         Transaction when
//  sample_i   in         read_ok, angle_sample           valid && ready
//  result_o   out        angle_out, angle_valid          valid && ready
//  cfg        in         cfg_we_i, cfg_idx_i, cfg_data_i cfg_we_i high
//
// One sample is in flight at a time. A good read with the Kalman stage on runs
// through the serial gain divider and the serial multipliers (one bit per cycle each);
// the low-pass adds its 17-bit coefficient multiply at the default sizes. A failed
// read skips the serial units, as does any stage that is bypassed.
// Reset (asynchronous, active low) loads the register defaults and the initial state.
// Results sit in an output register; the next sample is taken while it waits, and only
// the final hand-off stalls until the sink takes the previous transaction.
`default_nettype none

module angle_kalman_lowpass_tracker #(
  parameter int unsigned ANGLE_BITS    = aklt_pkg::ANGLE_BITS_DEF,
  parameter int unsigned VAR_FRAC_BITS = aklt_pkg::VAR_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  aklt_sample_if.sink                       sample_i,
  aklt_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [aklt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [aklt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import aklt_pkg::*;

  // Gain width (Q0.F with room for one), angle multiplier width, product widths.
  localparam int unsigned KW  = VAR_FRAC_BITS + 1;
  localparam int unsigned AMW = (KW > ALPHA_W) ? KW : ALPHA_W;
  localparam int unsigned APW = ANGLE_BITS + AMW;
  localparam int unsigned VPW = VAR_W + KW;

  localparam logic [KW-1:0]  K_ONE      = KW'(1) << VAR_FRAC_BITS;
  localparam logic [APW:0]   ANG_HALF_K = (APW + 1)'(1) << (VAR_FRAC_BITS - 1);
  localparam logic [APW:0]   ANG_HALF_L = (APW + 1)'(1) << (ALPHA_FRAC - 1);
  localparam logic [VPW:0]   VAR_HALF   = (VPW + 1)'(1) << (VAR_FRAC_BITS - 1);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,  // waiting for a sample
    S_PRED   = 9'b000000010,  // variance prediction and gain denominator
    S_DIVGO  = 9'b000000100,  // start the divider or take the zero-denominator case
    S_DIV    = 9'b000001000,  // divider running
    S_KMUL   = 9'b000010000,  // start innovation and variance multiplies
    S_KWAIT  = 9'b000100000,  // multiplies running, then Kalman update
    S_SMOOTH = 9'b001000000,  // low-pass seed, bypass or multiply start
    S_LWAIT  = 9'b010000000,  // low-pass multiply running, then update
    S_DONE   = 9'b100000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic                kalman_en_q;
  logic                lowpass_en_q;
  logic [VAR_W-1:0]    meas_noise_q;
  logic [VAR_W-1:0]    proc_noise_q;
  logic [ALPHA_W-1:0]  lp_alpha_q;

  // Filter state.
  logic [ANGLE_BITS-1:0] est_q, est_d;
  logic [ANGLE_BITS-1:0] smooth_q, smooth_d;
  logic [ANGLE_BITS-1:0] held_q, held_d;
  logic                  seeded_q, seeded_d;
  logic [VAR_W-1:0]      var_q, var_d;

  // Per-sample working registers.
  logic                  read_ok_q;
  logic [ANGLE_BITS-1:0] sample_q;
  logic [VAR_W-1:0]      pvar_q;
  logic [VAR_W:0]        den_q;
  logic                  step_neg_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [ANGLE_BITS-1:0] out_angle_q;
  logic                  out_flag_q;
  logic                  out_load;
  logic [ANGLE_BITS-1:0] result_angle;

  logic in_fire;

  // Prediction: P + Q saturated, then P + R kept at full width.
  logic [VAR_W:0]   pvar_sum;
  logic [VAR_W-1:0] pvar_sat;
  logic [VAR_W:0]   den_sum;

  // Wrapped difference shared by the innovation and the low-pass error.
  logic [ANGLE_BITS-1:0] diff_a, diff_b, diff, diff_mag;
  logic                  diff_neg;

  logic [ALPHA_W-1:0] alpha_sat;

  // Serial units.
  logic              div_start, div_busy;
  logic [KW-1:0]     div_quot;
  logic              ang_start, ang_busy;
  logic [AMW-1:0]    ang_mplr;
  logic [APW-1:0]    ang_prod;
  logic              var_start, var_busy;
  logic [VPW-1:0]    var_prod;

  // Rounded updates.
  logic [APW:0]          ang_rnd_k, ang_rnd_l;
  logic [ANGLE_BITS-1:0] step_mag, step_signed, apply_base, apply_sum;
  logic [VPW:0]          var_rnd;
  logic [VAR_W-1:0]      var_new;

  assign in_fire        = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == S_IDLE);

  assign pvar_sum = {1'b0, var_q} + {1'b0, proc_noise_q};
  assign pvar_sat = pvar_sum[VAR_W] ? '1 : pvar_sum[VAR_W-1:0];
  assign den_sum  = {1'b0, pvar_sat} + {1'b0, meas_noise_q};

  // In the Kalman step the difference is sample minus estimate; in the low-pass
  // step it is the new estimate minus the smoothed angle. An exact half turn
  // keeps its sign bit and so counts as minus half a turn.
  assign diff_a   = (state_q == S_KMUL) ? sample_q : est_q;
  assign diff_b   = (state_q == S_KMUL) ? est_q : smooth_q;
  assign diff     = diff_a - diff_b;
  assign diff_neg = diff[ANGLE_BITS-1];
  assign diff_mag = diff_neg ? (~diff + 1'b1) : diff;

  assign alpha_sat = (lp_alpha_q > ALPHA_ONE) ? ALPHA_ONE : lp_alpha_q;

  assign ang_mplr = (state_q == S_KMUL) ? AMW'(div_quot) : AMW'(alpha_sat);

  aklt_div #(
    .QUOT_W (KW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pvar_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // Angle multiplier: |innovation| * K, later |error| * alpha.
  aklt_mul #(
    .MCAND_W (ANGLE_BITS),
    .MPLR_W  (AMW)
  ) u_ang_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_start),
    .mcand_i (diff_mag),
    .mplr_i  (ang_mplr),
    .busy_o  (ang_busy),
    .prod_o  (ang_prod)
  );

  // Variance multiplier: (1 - K) * P.
  aklt_mul #(
    .MCAND_W (VAR_W),
    .MPLR_W  (KW)
  ) u_var_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (var_start),
    .mcand_i (pvar_q),
    .mplr_i  (K_ONE - div_quot),
    .busy_o  (var_busy),
    .prod_o  (var_prod)
  );

  // Magnitudes are rounded half up before the sign goes back on, which gives
  // rounding half away from zero. The step never exceeds half a turn.
  assign ang_rnd_k   = {1'b0, ang_prod} + ANG_HALF_K;
  assign ang_rnd_l   = {1'b0, ang_prod} + ANG_HALF_L;
  assign step_mag    = (state_q == S_LWAIT) ? ang_rnd_l[ALPHA_FRAC +: ANGLE_BITS]
                                            : ang_rnd_k[VAR_FRAC_BITS +: ANGLE_BITS];
  assign step_signed = step_neg_q ? (~step_mag + 1'b1) : step_mag;
  assign apply_base  = (state_q == S_LWAIT) ? smooth_q : est_q;
  assign apply_sum   = apply_base + step_signed;

  assign var_rnd = {1'b0, var_prod} + VAR_HALF;
  assign var_new = var_rnd[VAR_FRAC_BITS +: VAR_W];

  // A failed read repeats the last reported angle.
  assign result_angle = !read_ok_q ? held_q : (lowpass_en_q ? smooth_q : est_q);

  always_comb begin
    state_d     = state_q;
    est_d       = est_q;
    smooth_d    = smooth_q;
    held_d      = held_q;
    seeded_d    = seeded_q;
    var_d       = var_q;
    div_start   = 1'b0;
    ang_start   = 1'b0;
    var_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !result_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!sample_i.read_ok) begin
            state_d = S_DONE;
          end else if (kalman_en_q) begin
            state_d = S_PRED;
          end else begin
            est_d   = sample_i.angle_sample;
            state_d = S_SMOOTH;
          end
        end
      end
      S_PRED: begin
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        // Zero P + R only happens with P and R both zero: snap to the sample.
        if (den_q == '0) begin
          est_d   = sample_q;
          var_d   = '0;
          state_d = S_SMOOTH;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_KMUL;
        end
      end
      S_KMUL: begin
        ang_start = 1'b1;
        var_start = 1'b1;
        state_d   = S_KWAIT;
      end
      S_KWAIT: begin
        if (!ang_busy && !var_busy) begin
          est_d   = apply_sum;
          var_d   = var_new;
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        if (!lowpass_en_q) begin
          state_d = S_DONE;
        end else if (!seeded_q) begin
          smooth_d = est_q;
          seeded_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          ang_start = 1'b1;
          state_d   = S_LWAIT;
        end
      end
      S_LWAIT: begin
        if (!ang_busy) begin
          smooth_d = apply_sum;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          held_d      = result_angle;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Writes to the initial values reload the matching state.
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_VAR: begin
          var_d = cfg_data_i[VAR_W-1:0];
        end
        CFG_INIT_ANGLE: begin
          est_d    = cfg_data_i[ANGLE_BITS-1:0];
          smooth_d = cfg_data_i[ANGLE_BITS-1:0];
          held_d   = cfg_data_i[ANGLE_BITS-1:0];
          seeded_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      est_q       <= '0;
      smooth_q    <= '0;
      held_q      <= '0;
      seeded_q    <= 1'b0;
      var_q       <= RST_INIT_VAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      est_q       <= est_d;
      smooth_q    <= smooth_d;
      held_q      <= held_d;
      seeded_q    <= seeded_d;
      var_q       <= var_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kalman_en_q  <= RST_KALMAN_EN;
      lowpass_en_q <= RST_LOWPASS_EN;
      meas_noise_q <= RST_MEAS_NOISE;
      proc_noise_q <= RST_PROC_NOISE;
      lp_alpha_q   <= RST_LP_ALPHA;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KALMAN_EN:  kalman_en_q  <= cfg_data_i[0];
        CFG_LOWPASS_EN: lowpass_en_q <= cfg_data_i[0];
        CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i[VAR_W-1:0];
        CFG_PROC_NOISE: proc_noise_q <= cfg_data_i[VAR_W-1:0];
        CFG_LP_ALPHA:   lp_alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_ok_q <= sample_i.read_ok;
      sample_q  <= sample_i.angle_sample;
    end
    if (state_q == S_PRED) begin
      pvar_q <= pvar_sat;
      den_q  <= den_sum;
    end
    if (ang_start) begin
      step_neg_q <= diff_neg;
    end
    if (out_load) begin
      out_angle_q <= result_angle;
      out_flag_q  <= read_ok_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.angle_out   = out_angle_q;
  assign result_o.angle_valid = out_flag_q;

endmodule

`default_nettype wire

// File: test/angle_kalman_lowpass_tracker_test.sv
// Self-checking testbench for the angle Kalman / low-pass tracker with its own bit-exact predictor.
`timescale 1ns / 100ps

module angle_kalman_lowpass_tracker_test;
  import aklt_pkg::*;

  // The tracker is built with its default sizes, so the predictor uses the same ones.
  localparam int unsigned AW = ANGLE_BITS_DEF;
  localparam int unsigned VF = VAR_FRAC_BITS_DEF;

  typedef logic [AW-1:0] angle_t;

  // Index 7 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  localparam angle_t      RESET_ANGLE   = '0;
  localparam logic [63:0] VAR_ONE       = 64'd1 << VF;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 231;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PRINT_CAP     = 40;

  typedef struct packed {
    logic   ok;
    angle_t angle;
  } sample_t;

  typedef struct packed {
    angle_t angle;
    logic   valid;
  } angle_result_t;

  logic clk_i;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  aklt_sample_if sample_if ();
  aklt_result_if result_if ();

  angle_kalman_lowpass_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor copy of the configuration registers.
  logic           kal_on;
  logic           lp_on;
  logic [31:0]    r_noise;
  logic [31:0]    q_noise;
  logic [16:0]    alpha_reg;

  // Predictor copy of the filter state.
  angle_t         est_angle;
  logic [31:0]    est_var;
  angle_t         smooth_ang;
  logic           smooth_seeded;
  angle_t         held_angle;

  sample_t        pending_samples[$];
  angle_result_t  expected_results[$];

  sample_t        offer_item;
  int             samples_offered;
  int             samples_accepted;
  int             results_seen;
  int             bad_reads;
  int             cfg_writes;
  int             error_count;
  int             send_gap;
  int             stall_left;
  int             hold_left;
  logic           hold_request;
  int             holds_done;
  logic           idle_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Difference a - b modulo one turn, in [-half turn, half turn). An exact half turn
  // comes out as minus half a turn because the top bit is read as a sign.
  function automatic int wrap_delta(angle_t a, angle_t b);
    angle_t d;
    d = a - b;
    return int'($signed(d));
  endfunction

  // x * k / 2^sh, rounded to nearest with ties away from zero.
  function automatic int round_scale(int x, logic [63:0] k, int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    q   = (mag * k + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -int'(q) : int'(q);
  endfunction

  // Runs one accepted sample through the predicted filter and returns the result that
  // the tracker should hand out for it. A failed read repeats the held angle.
  function automatic angle_result_t track_sample(logic ok, angle_t sample);
    angle_result_t res;
    logic [63:0]   p;
    logic [63:0]   den;
    logic [63:0]   k;
    logic [63:0]   a;
    angle_t        x;
    if (!ok) begin
      res.angle = held_angle;
      res.valid = 1'b0;
      return res;
    end
    if (kal_on) begin
      // Variance grows by the process noise and saturates at the top of 32 bits.
      p = {32'd0, est_var} + {32'd0, q_noise};
      if (p > 64'hFFFF_FFFF) begin
        p = 64'hFFFF_FFFF;
      end
      den = p + {32'd0, r_noise};
      if (den == 0) begin
        // No uncertainty on either side: the gain is one and the sample is taken as is.
        est_angle = sample;
        est_var   = '0;
      end else begin
        k         = (p << VF) / den;
        est_angle = est_angle + angle_t'(round_scale(wrap_delta(sample, est_angle), k, VF));
        est_var   = 32'(((VAR_ONE - k) * p + (64'd1 << (VF - 1))) >> VF);
      end
    end else begin
      est_angle = sample;
    end
    x = est_angle;
    if (lp_on) begin
      if (!smooth_seeded) begin
        smooth_ang    = x;
        smooth_seeded = 1'b1;
      end else begin
        a = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
        smooth_ang = smooth_ang + angle_t'(round_scale(wrap_delta(x, smooth_ang), a, ALPHA_FRAC));
      end
      x = smooth_ang;
    end
    held_angle = x;
    res.angle  = x;
    res.valid  = 1'b1;
    return res;
  endfunction

  // Mirrors a register write into the predictor, including the state reloads.
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_KALMAN_EN:  kal_on  = data[0];
      CFG_LOWPASS_EN: lp_on   = data[0];
      CFG_MEAS_NOISE: r_noise = data;
      CFG_PROC_NOISE: q_noise = data;
      CFG_INIT_VAR: begin
        est_var = data;
      end
      CFG_INIT_ANGLE: begin
        est_angle     = data[AW-1:0];
        smooth_ang    = data[AW-1:0];
        held_angle    = data[AW-1:0];
        smooth_seeded = 1'b0;
      end
      CFG_LP_ALPHA:   alpha_reg = data[ALPHA_W-1:0];
      default: ;
    endcase
  endfunction

  // Idle lengths for both channels: mostly none or short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 60);
  endfunction

  // Variance-style register values, extremes included.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  // One register write per call; the write enable stays high across back-to-back calls
  // and is lowered by cfg_done. Writes happen only while the tracker is idle, so the
  // predictor can take the new value right away.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_cfg(idx, data);
    cfg_writes++;
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every queued sample has gone in and every expected result has come
  // out, then lets the tracker settle before anything else is changed.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || samples_offered != samples_accepted ||
           expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic ok, input angle_t angle);
    sample_t s;
    s.ok    = ok;
    s.angle = angle;
    pending_samples.push_back(s);
  endtask

  // Sender. The item on the channel is replaced only after the monitor has seen its
  // transaction; the gap drawn when it was offered is spent after it was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else if (samples_offered == samples_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        offer_item = pending_samples.pop_front();
        sample_if.valid        <= 1'b1;
        sample_if.read_ok      <= offer_item.ok;
        sample_if.angle_sample <= offer_item.angle;
        samples_offered++;
        send_gap = idle_off ? 0 : idle_length();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Receiver. Besides the random stalls it can be told to hold off for a long stretch,
  // which it counts itself; meanwhile the sender keeps offering, so the tracker fills
  // its output register, finishes the next sample and then stalls its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      holds_done++;
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 3) == 0) begin
      stall_left = idle_length();
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Monitor. It watches both channels at the rising edge: a sample transaction feeds
  // the predictor, a result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    angle_result_t want;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result angle %h valid %b with nothing expected",
                                    result_if.angle_out, result_if.angle_valid));
        end else begin
          want = expected_results.pop_front();
          if (result_if.angle_out !== want.angle) begin
            report_mismatch($sformatf("result %0d angle_out %h, expected %h",
                                      results_seen, result_if.angle_out, want.angle));
          end
          if (result_if.angle_valid !== want.valid) begin
            report_mismatch($sformatf("result %0d angle_valid %b, expected %b",
                                      results_seen, result_if.angle_valid, want.valid));
          end
        end
        results_seen++;
      end
      if (sample_if.valid && sample_if.ready) begin
        expected_results.push_back(track_sample(sample_if.read_ok, sample_if.angle_sample));
        if (!sample_if.read_ok) begin
          bad_reads++;
        end
        samples_accepted++;
      end
    end
  end

  // Stimulus: reset, a directed part over the special cases, then random settings
  // phases with encoder-like trajectories mixed with noise and failed-read bursts.
  initial begin
    angle_t pos;
    int     vel;
    int     fail_run;
    int     r;
    logic   ok;
    angle_t angle;

    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_data               = '0;
    sample_if.valid        = 1'b0;
    sample_if.read_ok      = 1'b0;
    sample_if.angle_sample = '0;
    result_if.ready        = 1'b0;
    samples_offered        = 0;
    samples_accepted       = 0;
    results_seen           = 0;
    bad_reads              = 0;
    cfg_writes             = 0;
    error_count            = 0;
    send_gap               = 0;
    stall_left             = 0;
    hold_left              = 0;
    hold_request           = 1'b0;
    holds_done             = 0;
    idle_off               = 1'b0;

    kal_on        = RST_KALMAN_EN;
    lp_on         = RST_LOWPASS_EN;
    r_noise       = RST_MEAS_NOISE;
    q_noise       = RST_PROC_NOISE;
    alpha_reg     = RST_LP_ALPHA;
    est_angle     = RESET_ANGLE;
    est_var       = RST_INIT_VAR;
    smooth_ang    = RESET_ANGLE;
    smooth_seeded = 1'b0;
    held_angle    = RESET_ANGLE;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings. The first sample sits exactly half a turn from the start angle.
    push_sample(1'b1, 16'h8000);
    push_sample(1'b1, 16'h0000);
    push_sample(1'b1, 16'hFFFF);
    push_sample(1'b0, 16'hFFFF);
    push_sample(1'b0, 16'h0000);
    push_sample(1'b1, 16'h7FFF);
    push_sample(1'b1, 16'h0001);
    wait_drained();

    // Zero variances on both sides: the gain is forced to one.
    cfg_write(CFG_INIT_VAR, 32'd0);
    cfg_write(CFG_PROC_NOISE, 32'd0);
    cfg_write(CFG_MEAS_NOISE, 32'd0);
    cfg_done();
    push_sample(1'b1, 16'h1234);
    push_sample(1'b1, 16'hFFFF);
    push_sample(1'b0, 16'h5555);
    wait_drained();

    // Largest variances: P + Q saturates and R is at its top.
    cfg_write(CFG_INIT_VAR, 32'hFFFF_FFFF);
    cfg_write(CFG_PROC_NOISE, 32'hFFFF_FFFF);
    cfg_write(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
    cfg_done();
    push_sample(1'b1, 16'h4000);
    push_sample(1'b1, 16'hC000);
    wait_drained();

    // Kalman bypassed, low-pass on with a coefficient above one; the new start angle
    // clears the seed, so the first good read seeds the low-pass.
    cfg_write(CFG_KALMAN_EN, 32'd0);
    cfg_write(CFG_LOWPASS_EN, 32'd1);
    cfg_write(CFG_LP_ALPHA, 32'hFFFF_FFFF);
    cfg_write(CFG_INIT_ANGLE, 32'h0000_FFF0);
    cfg_done();
    push_sample(1'b1, 16'h0010);
    push_sample(1'b1, 16'hFFF8);
    push_sample(1'b0, 16'h0000);
    wait_drained();

    // Coefficient of exactly one.
    cfg_write(CFG_LP_ALPHA, {15'd0, ALPHA_ONE});
    cfg_done();
    push_sample(1'b1, 16'h8000);
    push_sample(1'b1, 16'h0000);
    wait_drained();

    // Back to the Kalman stage with a frozen low-pass; a write to the unused index
    // must leave everything alone.
    cfg_write(CFG_KALMAN_EN, 32'd1);
    cfg_write(CFG_MEAS_NOISE, RST_MEAS_NOISE);
    cfg_write(CFG_PROC_NOISE, RST_PROC_NOISE);
    cfg_write(CFG_INIT_VAR, RST_INIT_VAR);
    cfg_write(CFG_LP_ALPHA, 32'd0);
    cfg_write(CFG_INIT_ANGLE, 32'hFFFF_8000);
    cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    cfg_done();
    push_sample(1'b1, 16'h0123);
    push_sample(1'b1, 16'hFEDC);
    push_sample(1'b0, 16'hAAAA);
    push_sample(1'b1, 16'h8123);
    wait_drained();

    pos      = angle_t'($urandom);
    vel      = 0;
    fail_run = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Each register is rewritten with a fair chance; the others keep their values.
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_KALMAN_EN, $urandom);
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_LOWPASS_EN, $urandom);
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_MEAS_NOISE, pick_word());
      if ($urandom_range(0, 3) != 0) begin
        cfg_write(CFG_PROC_NOISE, ($urandom_range(0, 3) == 0) ? pick_word()
                                                               : 32'($urandom_range(0, 4096)));
      end
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_INIT_VAR, pick_word());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_INIT_ANGLE, $urandom);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       cfg_write(CFG_LP_ALPHA, 32'd0);
          1:       cfg_write(CFG_LP_ALPHA, {15'd0, ALPHA_ONE});
          2:       cfg_write(CFG_LP_ALPHA, 32'($urandom_range(65537, 131071)));
          3:       cfg_write(CFG_LP_ALPHA, $urandom);
          default: cfg_write(CFG_LP_ALPHA, 32'($urandom_range(0, 65535)));
        endcase
      end
      if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED_IDX, $urandom);
      cfg_done();

      // Every third phase runs without idling on either side.
      idle_off = (phase % 3 == 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (fail_run > 0) begin
          // Inside a burst of failed reads the sample lines carry garbage.
          fail_run--;
          ok    = 1'b0;
          angle = angle_t'($urandom);
        end else if (r < 8) begin
          ok    = 1'($urandom_range(0, 1));
          angle = angle_t'($urandom);
        end else if (r < 12) begin
          ok = 1'b1;
          case ($urandom_range(0, 3))
            0:       angle = 16'h0000;
            1:       angle = 16'hFFFF;
            2:       angle = 16'h8000;
            default: angle = 16'h7FFF;
          endcase
        end else begin
          // A rotating encoder with a little read noise; the speed changes now and then.
          if ($urandom_range(0, 99) < 3) begin
            vel = int'($urandom_range(0, 4000)) - 2000;
          end
          if ($urandom_range(0, 99) < 2) begin
            fail_run = $urandom_range(3, 8);
          end
          pos   = pos + angle_t'(vel);
          angle = pos + angle_t'(int'($urandom_range(0, 64)) - 32);
          ok    = ($urandom_range(0, 9) != 0);
        end
        push_sample(ok, angle);
      end
      if (phase == 3) begin
        hold_request = 1'b1;
      end
      wait_drained();
    end

    idle_off = 1'b0;
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end

    $display("Checked %0d results for %0d samples (%0d failed reads), %0d register writes.",
             results_seen, samples_accepted, bad_reads, cfg_writes);
    $display("Ran %0d random settings phases and %0d long receiver hold-off; %0d mismatches.",
             RANDOM_PHASES, holds_done, error_count);
    if (error_count == 0) begin
      $display("angle_kalman_lowpass_tracker_test: done, clean");
    end else begin
      $display("angle_kalman_lowpass_tracker_test: done, errors");
    end
    $finish;
  end

  // Guards against a hung handshake; several times the slowest legal run.
  initial begin
    #2_500_000;
    $display("angle_kalman_lowpass_tracker_test: done, errors");
    $finish;
  end

endmodule
